FILE: rtl/dq_pkg.sv
// Shared constants and types for the double-ended queue.
// Used by dq_store and double_ended_queue; depends on nothing else.
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

  // Command codes.
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_REAR   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Access request from the sequencer to the element store.
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
  } store_req_t;

endpackage

FILE: rtl/dq_store.sv
// Element store of the double-ended queue: one write port, one registered read port.
// Depends on dq_pkg.
module dq_store (
  input  logic                       clk,
  input  dq_pkg::store_req_t         req,
  output logic [dq_pkg::DATA_W-1:0]  rd_data
);

  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];

  // Write first-come, read data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

FILE: rtl/double_ended_queue.sv
// Double-ended queue over a linear store of dq_pkg::DEPTH entries.
// Depends on dq_pkg and dq_store.
//
// Usage: one command transaction (command, value) is taken on the cmd channel
// and exactly one response transaction (popped_value, status, occupancy) is
// returned on the rsp channel, in order. Both channels use valid/ready.
// The block works on one command at a time; cmd_ready is high only when the
// sequencer is idle and the response register is empty or being drained.
// Path from command to response valid:
//   pushes that need no move, refused commands, empty pops: the response is
//   registered as the command is taken; successful pops: via S_POP, set by the
//   registered read of the store; push front while front sits at slot zero:
//   via S_SHIFT and S_FILL, since the held entries move up one slot per cycle
//   through the single read and write port of the store.
// A new command waits until the last is done; it can be taken while the response is drained.
// When the receiver stalls, the response holds in its register and no new
// command is taken until it leaves. Reset empties the queue (both indices
// zero) and drops any pending response; store contents are left as they are.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [1:0]                        command,
  input  logic signed [dq_pkg::DATA_W-1:0]  value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic signed [dq_pkg::DATA_W-1:0]  popped_value,
  output logic [1:0]                        status,
  output logic [dq_pkg::CNT_W-1:0]          occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SHIFT,
    S_FILL
  } state_t;

  state_t                     state;
  logic [dq_pkg::IDX_W-1:0]   front;
  logic [dq_pkg::IDX_W-1:0]   rear;
  logic                       is_empty;
  logic [dq_pkg::IDX_W-1:0]   shift_idx;
  logic [dq_pkg::DATA_W-1:0]  hold_value;

  dq_pkg::store_req_t         req;
  logic [dq_pkg::DATA_W-1:0]  rd_data;
  logic                       accept;
  logic                       at_last;
  logic [dq_pkg::CNT_W-1:0]   occ_now;

  dq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = cmd_valid && cmd_ready;
  assign at_last   = (rear == dq_pkg::LAST_SLOT);
  assign occ_now   = is_empty ? '0
                   : dq_pkg::CNT_W'(rear) - dq_pkg::CNT_W'(front) + dq_pkg::CNT_W'(1);

  // Store access for the current step of the sequencer.
  always_comb begin
    req.wr_en   = 1'b0;
    req.wr_addr = rear;
    req.wr_data = $unsigned(value);
    req.rd_addr = front;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            dq_pkg::CMD_PUSH_FRONT: begin
              if (is_empty) begin
                req.wr_en   = 1'b1;
                req.wr_addr = '0;
              end else if (front != '0) begin
                req.wr_en   = 1'b1;
                req.wr_addr = front - dq_pkg::IDX_W'(1);
              end else begin
                // Start the move: fetch the top entry first.
                req.rd_addr = rear;
              end
            end
            dq_pkg::CMD_PUSH_REAR: begin
              if (is_empty) begin
                req.wr_en   = 1'b1;
                req.wr_addr = '0;
              end else if (!at_last) begin
                req.wr_en   = 1'b1;
                req.wr_addr = rear + dq_pkg::IDX_W'(1);
              end
            end
            dq_pkg::CMD_POP_FRONT: begin
              req.rd_addr = front;
            end
            dq_pkg::CMD_POP_REAR: begin
              req.rd_addr = rear;
            end
            default: begin
              req.rd_addr = front;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Write the entry fetched last cycle one slot higher, fetch the next.
        req.wr_en   = 1'b1;
        req.wr_addr = shift_idx;
        req.wr_data = rd_data;
        req.rd_addr = shift_idx - dq_pkg::IDX_W'(1) - dq_pkg::IDX_W'(1);
      end
      S_FILL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = '0;
        req.wr_data = hold_value;
      end
      default: begin
        req.wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, queue indices and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      rear      <= '0;
      is_empty  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (command)
              dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
                popped_value <= '0;
                if (is_empty) begin
                  front     <= '0;
                  rear      <= '0;
                  is_empty  <= 1'b0;
                  rsp_valid <= 1'b1;
                  status    <= dq_pkg::ST_DONE;
                  occupancy <= occ_now + dq_pkg::CNT_W'(1);
                end else if (command == dq_pkg::CMD_PUSH_FRONT && front != '0) begin
                  front     <= front - dq_pkg::IDX_W'(1);
                  rsp_valid <= 1'b1;
                  status    <= dq_pkg::ST_DONE;
                  occupancy <= occ_now + dq_pkg::CNT_W'(1);
                end else if (at_last) begin
                  rsp_valid <= 1'b1;
                  status    <= dq_pkg::ST_FULL;
                  occupancy <= occ_now;
                end else if (command == dq_pkg::CMD_PUSH_REAR) begin
                  rear      <= rear + dq_pkg::IDX_W'(1);
                  rsp_valid <= 1'b1;
                  status    <= dq_pkg::ST_DONE;
                  occupancy <= occ_now + dq_pkg::CNT_W'(1);
                end else begin
                  // Front sits at slot zero: move every entry up first.
                  shift_idx  <= rear + dq_pkg::IDX_W'(1);
                  hold_value <= $unsigned(value);
                  state      <= S_SHIFT;
                end
              end
              default: begin
                // Pop from either end.
                if (is_empty) begin
                  popped_value <= '1;
                  rsp_valid    <= 1'b1;
                  status       <= dq_pkg::ST_EMPTY;
                  occupancy    <= '0;
                end else begin
                  status    <= dq_pkg::ST_DONE;
                  occupancy <= occ_now - dq_pkg::CNT_W'(1);
                  state     <= S_POP;
                  if (front == rear) begin
                    is_empty <= 1'b1;
                    front    <= '0;
                    rear     <= '0;
                  end else if (command == dq_pkg::CMD_POP_FRONT) begin
                    front <= front + dq_pkg::IDX_W'(1);
                  end else begin
                    rear <= rear - dq_pkg::IDX_W'(1);
                  end
                end
              end
            endcase
          end
        end
        S_POP: begin
          popped_value <= $signed(rd_data);
          rsp_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        S_SHIFT: begin
          if (shift_idx == dq_pkg::IDX_W'(1)) begin
            state <= S_FILL;
          end else begin
            shift_idx <= shift_idx - dq_pkg::IDX_W'(1);
          end
        end
        S_FILL: begin
          rear         <= rear + dq_pkg::IDX_W'(1);
          popped_value <= '0;
          status       <= dq_pkg::ST_DONE;
          occupancy    <= occ_now + dq_pkg::CNT_W'(1);
          rsp_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An empty queue always has both indices at slot zero.
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (front == '0 && rear == '0))
    else $error("empty queue with nonzero index");

  // Held entries are contiguous from front up to rear.
  a_order: assert property (@(posedge clk) disable iff (rst)
    !is_empty |-> (front <= rear))
    else $error("front above rear");

  // The move never targets slot zero; slot zero is written by the fill step.
  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (shift_idx != '0))
    else $error("move step targets slot zero");

  // The move only runs with front at slot zero and room at the top.
  a_shift_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (front == '0 && !at_last && !is_empty))
    else $error("move started without room");

  // A pop read always completes with a response in the next cycle.
  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (rsp_valid && state == S_IDLE))
    else $error("pop did not produce a response");
`endif

endmodule
